[rtl/dje_pkg.sv]
package dje_pkg;

  typedef enum logic [1:0] {
    EV_LEFT  = 2'd0,
    EV_RIGHT = 2'd1,
    EV_MOVE  = 2'd2
  } event_kind_e;

  // bit positions of the active-low switch port
  localparam int unsigned BIT_SW2   = 1;
  localparam int unsigned BIT_SW3   = 2;
  localparam int unsigned BIT_PUSH  = 3;
  localparam int unsigned BIT_RIGHT = 4;
  localparam int unsigned BIT_DOWN  = 5;
  localparam int unsigned BIT_LEFT  = 6;
  localparam int unsigned BIT_UP    = 7;

  localparam int unsigned SENS_W     = 7;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned ADDR_LSB   = 2;
  localparam logic        REG_SENSITIVITY = 1'b0;
  localparam logic [SENS_W-1:0] SENS_RESET = 7'd1;
  localparam logic [7:0]  PORT_RESET = 8'h00;

  typedef struct packed {
    logic [7:0] port_sample;
  } in_item_t;

  typedef struct packed {
    event_kind_e       event_kind;
    logic              button_down;
    logic signed [7:0] x_move;
    logic signed [7:0] y_move;
    logic              last;
  } out_item_t;

endpackage

[rtl/dje_stream_if.sv]
interface dje_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/debounced_joystick_mouse_events_top.sv]
// Channel   | Dir | Payload                                          | Handshake
// ----------+-----+--------------------------------------------------+------------
// in_i      | in  | port_sample[7:0]                                 | valid/ready
// out_o     | out | event_kind, button_down, x_move, y_move, last    | valid/ready
// APB       | in  | sensitivity at 0x0                               | psel/penable
//
// An item yields one to three results, one per cycle while out_o is ready; the first
// reaches out_o through the pending set and then the output register. Items are paced
// by draining the pending result set through the single output register.
// in_i.ready rises again in the cycle the last pending result moves to the output.
// Reset clears the debounce state, button state and pending set; sensitivity goes to 1.
// Output stalls hold the output register and the pending set.
module debounced_joystick_mouse_events_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dje_stream_if.sink                  in_i,
  dje_stream_if.source                out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dje_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [dje_pkg::SENS_W-1:0] sens_q;
  logic [7:0]                 prev_q, deb_q;
  logic                       left_held_q, right_held_q;

  // pending results: bit0 left event, bit1 right event, bit2 movement
  logic [2:0]                 pend_q, pend_d, pend_sel, pend_left;
  logic                       left_dn_q, right_dn_q;
  logic signed [7:0]          x_q, y_q;

  logic                       out_valid_q;
  dje_pkg::out_item_t         out_q, out_d;

  logic                       load, in_acc, cfg_wr;
  logic [7:0]                 sample, deb_d;
  logic                       left_now, right_now;
  logic signed [7:0]          pos, neg, x_d, y_d;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[dje_pkg::ADDR_LSB] == dje_pkg::REG_SENSITIVITY);
  assign prdata = (paddr[dje_pkg::ADDR_LSB] == dje_pkg::REG_SENSITIVITY) ?
                  {{(32-dje_pkg::SENS_W){1'b0}}, sens_q} : 32'd0;

  // ---------------- input side ----------------
  assign sample    = in_i.data.port_sample;
  assign deb_d     = (prev_q == sample) ? prev_q : deb_q;
  assign left_now  = !deb_d[dje_pkg::BIT_SW2] || !deb_d[dje_pkg::BIT_PUSH];
  assign right_now = !deb_d[dje_pkg::BIT_SW3];
  assign pos       = signed'({1'b0, sens_q});
  assign neg       = 8'sd0 - pos;

  always_comb begin
    if (!deb_d[dje_pkg::BIT_UP]) begin
      y_d = neg;
    end else if (!deb_d[dje_pkg::BIT_DOWN]) begin
      y_d = pos;
    end else begin
      y_d = 8'sd0;
    end
    if (!deb_d[dje_pkg::BIT_RIGHT]) begin
      x_d = pos;
    end else if (!deb_d[dje_pkg::BIT_LEFT]) begin
      x_d = neg;
    end else begin
      x_d = 8'sd0;
    end
  end

  // ---------------- pending set to output register ----------------
  assign load = (pend_q != 3'b000) && (!out_valid_q || out_o.ready);

  always_comb begin
    if (pend_q[0]) begin
      pend_sel = 3'b001;
    end else if (pend_q[1]) begin
      pend_sel = 3'b010;
    end else begin
      pend_sel = 3'b100;
    end
  end

  assign pend_left  = load ? (pend_q & ~pend_sel) : pend_q;
  assign in_i.ready = (pend_left == 3'b000);
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    if (in_acc) begin
      pend_d = {1'b1, right_now != right_held_q, left_now != left_held_q};
    end else begin
      pend_d = pend_left;
    end
  end

  always_comb begin
    out_d.event_kind  = dje_pkg::EV_MOVE;
    out_d.button_down = 1'b0;
    out_d.x_move      = 8'sd0;
    out_d.y_move      = 8'sd0;
    out_d.last        = 1'b0;
    if (pend_sel[0]) begin
      out_d.event_kind  = dje_pkg::EV_LEFT;
      out_d.button_down = left_dn_q;
    end else if (pend_sel[1]) begin
      out_d.event_kind  = dje_pkg::EV_RIGHT;
      out_d.button_down = right_dn_q;
    end else begin
      out_d.x_move = x_q;
      out_d.y_move = y_q;
      out_d.last   = 1'b1;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q       <= dje_pkg::SENS_RESET;
      prev_q       <= dje_pkg::PORT_RESET;
      deb_q        <= dje_pkg::PORT_RESET;
      left_held_q  <= 1'b0;
      right_held_q <= 1'b0;
      pend_q       <= 3'b000;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        sens_q <= pwdata[dje_pkg::SENS_W-1:0];
      end
      if (in_acc) begin
        prev_q       <= sample;
        deb_q        <= deb_d;
        left_held_q  <= left_now;
        right_held_q <= right_now;
      end
      pend_q <= pend_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_dn_q  <= left_now;
      right_dn_q <= right_now;
      x_q        <= x_d;
      y_q        <= y_d;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

`ifndef NO_ASSERTIONS
  // movement report is always the last one pending
  a_move_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 3'b000) |-> pend_q[2])
    else $error("pending set lacks movement report");

  a_acc_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pend_q[2])
    else $error("accepted item did not queue a movement report");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.event_kind == dje_pkg::EV_MOVE)))
    else $error("last flag does not match event kind");

  a_button_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_kind != dje_pkg::EV_MOVE) |->
      (out_q.x_move == 8'sd0 && out_q.y_move == 8'sd0))
    else $error("button event carries movement");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result was overwritten");
`endif

endmodule

[dv/tb.sv]
module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [dje_pkg::ADDR_W-1:0] ADDR_SENS   = (dje_pkg::ADDR_W)'(0);
  // index 1, no register there
  localparam logic [dje_pkg::ADDR_W-1:0] ADDR_UNUSED = (dje_pkg::ADDR_W)'(4);

  logic clk_i;
  logic rst_ni;

  dje_stream_if #(.T(dje_pkg::in_item_t))  port_if ();
  dje_stream_if #(.T(dje_pkg::out_item_t)) report_if ();

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [dje_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  debounced_joystick_mouse_events_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (port_if),
    .out_o   (report_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state, starts at reset values
  logic [dje_pkg::SENS_W-1:0] sensitivity = dje_pkg::SENS_RESET;
  logic [7:0]                 prev_sample = dje_pkg::PORT_RESET;
  logic [7:0]                 stable_port = dje_pkg::PORT_RESET;
  logic                       left_down   = 1'b0;
  logic                       right_down  = 1'b0;

  dje_pkg::in_item_t  sample_q[$];
  dje_pkg::out_item_t report_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        port_taken    = 1'b0;
  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;
  int unsigned samples_taken = 0;
  int unsigned reports_seen  = 0;
  int unsigned button_events = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_reports(input logic [7:0] sample);
    dje_pkg::out_item_t rep;
    logic [7:0]         d;
    logic               now_down;
    logic signed [7:0]  step;
    if (prev_sample == sample) stable_port = prev_sample;
    prev_sample = sample;
    d = stable_port;
    step = $signed({1'b0, sensitivity});

    now_down = !d[dje_pkg::BIT_SW2] || !d[dje_pkg::BIT_PUSH];
    if (now_down != left_down) begin
      left_down = now_down;
      rep = '0;
      rep.event_kind = dje_pkg::EV_LEFT;
      rep.button_down = now_down;
      report_q.push_back(rep);
    end

    now_down = !d[dje_pkg::BIT_SW3];
    if (now_down != right_down) begin
      right_down = now_down;
      rep = '0;
      rep.event_kind = dje_pkg::EV_RIGHT;
      rep.button_down = now_down;
      report_q.push_back(rep);
    end

    rep = '0;
    rep.event_kind = dje_pkg::EV_MOVE;
    rep.last = 1'b1;
    if (!d[dje_pkg::BIT_UP]) rep.y_move = -step;
    else if (!d[dje_pkg::BIT_DOWN]) rep.y_move = step;
    if (!d[dje_pkg::BIT_RIGHT]) rep.x_move = step;
    else if (!d[dje_pkg::BIT_LEFT]) rep.x_move = -step;
    report_q.push_back(rep);
  endfunction

  // sender: a new item is offered once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!port_if.valid || port_taken) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          port_if.valid <= 1'b1;
          port_if.data  <= sample_q.pop_front();
        end else begin
          port_if.valid <= 1'b0;
        end
      end
      report_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    dje_pkg::out_item_t want;
    dje_pkg::out_item_t got;
    port_taken <= port_if.valid && port_if.ready;

    if (psel && penable && pwrite && pready &&
        paddr[dje_pkg::ADDR_W-1:dje_pkg::ADDR_LSB] == dje_pkg::REG_SENSITIVITY)
      sensitivity = pwdata[dje_pkg::SENS_W-1:0];

    if (port_if.valid && port_if.ready) begin
      samples_taken++;
      predict_reports(port_if.data.port_sample);
    end

    if (report_if.valid && report_if.ready) begin
      got = report_if.data;
      reports_seen++;
      if (report_q.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected item: expected none, got kind=%0d down=%0d x=%0d y=%0d last=%0d",
                 $time, got.event_kind, got.button_down, got.x_move, got.y_move, got.last);
      end else begin
        want = report_q.pop_front();
        if (want.event_kind != dje_pkg::EV_MOVE) button_events++;
        if (got.event_kind !== want.event_kind || got.button_down !== want.button_down ||
            got.x_move !== want.x_move || got.y_move !== want.y_move ||
            got.last !== want.last) begin
          err_cnt++;
          $display("%0t mismatch: expected kind=%0d down=%0d x=%0d y=%0d last=%0d,",
                   $time, want.event_kind, want.button_down, want.x_move, want.y_move,
                   want.last);
          $display("%0t           got kind=%0d down=%0d x=%0d y=%0d last=%0d",
                   $time, got.event_kind, got.button_down, got.x_move, got.y_move,
                   got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycle_cnt,
               report_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [dje_pkg::ADDR_W-1:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_sample(input logic [7:0] v, input int unsigned reps);
    repeat (reps) sample_q.push_back(dje_pkg::in_item_t'(v));
  endtask

  // mostly held patterns (two or more equal samples), some bounce noise
  task automatic fill_random(input int unsigned n);
    int unsigned cnt;
    int unsigned reps;
    logic [7:0]  v;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(1) == 0) begin
        v = 8'hFF;
        repeat ($urandom_range(3)) v[$urandom_range(7)] = 1'b0;
      end else begin
        v = 8'($urandom);
      end
      reps = ($urandom_range(99) < 80) ? $urandom_range(4, 2) : 1;
      push_sample(v, reps);
      cnt += reps;
    end
  endtask

  // hold off until every queued item is taken and every report has come back
  task automatic drain();
    while (sample_q.size() != 0 || port_if.valid || report_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned idle,
                           input int unsigned stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    fill_random(n);
    drain();
  endtask

  initial begin
    port_if.valid   = 1'b0;
    port_if.data    = '0;
    report_if.ready = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: first pair sees the all-pressed reset port
    push_sample(8'hFF, 2);
    push_sample(8'hFE, 2);  // sw1 alone does nothing
    push_sample(8'hFD, 2);  // sw2 -> left press
    push_sample(8'hF7, 2);  // push keeps left held
    push_sample(8'hFB, 2);  // left release, right press
    push_sample(8'h7F, 2);  // up
    push_sample(8'hDF, 2);  // down
    push_sample(8'h5F, 2);  // up beats down
    push_sample(8'hEF, 2);  // right
    push_sample(8'hBF, 2);  // left
    push_sample(8'hAF, 2);  // right beats left
    push_sample(8'h00, 2);
    push_sample(8'h55, 1);  // bouncing, no update
    push_sample(8'hAA, 1);
    drain();

    reg_write(ADDR_UNUSED, 32'h0000_0040);
    run_phase(100, 0, 0);
    reg_write(ADDR_SENS, 32'hFFFF_FFFF);  // upper bits dropped -> 127
    run_phase(100, 64, 0);
    reg_write(ADDR_SENS, 32'h0000_0000);
    run_phase(100, 0, 64);
    reg_write(ADDR_SENS, 32'($urandom_range(126, 2)));
    run_phase(100, 17, 17);

    $display("Covered %0d port samples, %0d reports (%0d button events)", samples_taken,
             reports_seen, button_events);
    $display("across sensitivity 1/127/0/random, unused register write, four pacing phases");
    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
